// ===== design/otc_pkg.sv =====
package otc_pkg;

   localparam int TRIM_BITS   = 8;
   localparam int LENGTH_BITS = 16;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [LENGTH_BITS-1:0] TARGET_RESET = LENGTH_BITS'(2356);

   // word index of the target length register
   localparam logic [CSR_ADDR_BITS-1:0] REG_TARGET_LENGTH = '0;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_MEASURE = 1'b1;

   typedef struct packed {
      logic [TRIM_BITS-1:0] trim;
      logic                 done_res;
   } otc_result_type;

endpackage

// ===== design/otc_ifs.sv =====
interface otc_req_if import otc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [LENGTH_BITS-1:0] frame_length;

   modport source (output valid, output command, output frame_length, input ready);
   modport sink   (input valid, input command, input frame_length, output ready);
endinterface

interface otc_rsp_if import otc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TRIM_BITS-1:0] trim;
   logic                 done_res;

   modport source (output valid, output trim, output done_res, input ready);
   modport sink   (input valid, input trim, input done_res, output ready);
endinterface

// ===== design/otc_csr.sv =====
module otc_csr import otc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [LENGTH_BITS-1:0]   target_length
);

   logic [LENGTH_BITS-1:0] target_length_ff;
   logic [LENGTH_BITS-1:0] target_length_in;
   logic                   write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == REG_TARGET_LENGTH);

   always_comb begin
      target_length_in = target_length_ff;
      if (write_hit) begin
         target_length_in = csr_pwdata[LENGTH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_length_ff <= TARGET_RESET;
      end else begin
         target_length_ff <= target_length_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == REG_TARGET_LENGTH) begin
         csr_prdata = CSR_DATA_BITS'(target_length_ff);
      end
   end

   assign target_length = target_length_ff;

endmodule

// ===== design/otc_core.sv =====
module otc_core import otc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   command,
   input  logic [LENGTH_BITS-1:0] frame_length,
   input  logic [LENGTH_BITS-1:0] target_length,
   output otc_result_type         result
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SEARCH = 2'd1;
   localparam logic [1:0] PH_NEIGH  = 2'd2;

   localparam logic [TRIM_BITS-1:0] TRIM_MAX = '1;
   localparam logic [TRIM_BITS-1:0] STEP_TOP = TRIM_BITS'(1) << (TRIM_BITS - 1);

   logic [1:0]             phase_ff, phase_in;
   logic [TRIM_BITS-1:0]   step_bit_ff, step_bit_in;
   logic [TRIM_BITS-1:0]   search_value_ff, search_value_in;
   logic [TRIM_BITS-1:0]   candidate_ff, candidate_in;
   logic [TRIM_BITS-1:0]   best_trim_ff, best_trim_in;
   logic [LENGTH_BITS-1:0] best_deviation_ff, best_deviation_in;

   logic [TRIM_BITS-1:0]   kept_value;
   logic [TRIM_BITS-1:0]   next_step;
   logic [LENGTH_BITS-1:0] deviation;
   logic [TRIM_BITS-1:0]   top;
   logic [TRIM_BITS-1:0]   best_now;

   always_comb begin
      kept_value = (frame_length < target_length) ? search_value_ff + step_bit_ff
                                                  : search_value_ff;
      next_step  = step_bit_ff >> 1;
      deviation  = (frame_length >= target_length) ? frame_length - target_length
                                                   : target_length - frame_length;
      top        = (search_value_ff == TRIM_MAX) ? TRIM_MAX : search_value_ff + 1'b1;
      best_now   = (deviation < best_deviation_ff) ? candidate_ff : best_trim_ff;
   end

   always_comb begin
      phase_in          = phase_ff;
      step_bit_in       = step_bit_ff;
      search_value_in   = search_value_ff;
      candidate_in      = candidate_ff;
      best_trim_in      = best_trim_ff;
      best_deviation_in = best_deviation_ff;
      result.trim       = best_trim_ff;
      result.done_res   = 1'b0;

      if (command == CMD_START) begin
         // a start always restarts the search from the top bit
         phase_in        = PH_SEARCH;
         step_bit_in     = STEP_TOP;
         search_value_in = '0;
         result.trim     = STEP_TOP;
      end else begin
         case (phase_ff)
            PH_SEARCH: begin
               search_value_in = kept_value;
               step_bit_in     = next_step;
               if (next_step != '0) begin
                  result.trim = kept_value + next_step;
               end else begin
                  // deviation starts at the raw last measurement
                  best_trim_in      = kept_value;
                  best_deviation_in = frame_length;
                  candidate_in      = (kept_value == '0) ? '0 : kept_value - 1'b1;
                  phase_in          = PH_NEIGH;
                  result.trim       = (kept_value == '0) ? '0 : kept_value - 1'b1;
               end
            end
            PH_NEIGH: begin
               if (deviation < best_deviation_ff) begin
                  best_deviation_in = deviation;
                  best_trim_in      = candidate_ff;
               end
               if (candidate_ff < top) begin
                  candidate_in = candidate_ff + 1'b1;
                  result.trim  = candidate_ff + 1'b1;
               end else begin
                  phase_in        = PH_IDLE;
                  result.trim     = best_now;
                  result.done_res = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         step_bit_ff       <= '0;
         search_value_ff   <= '0;
         candidate_ff      <= '0;
         best_trim_ff      <= '0;
         best_deviation_ff <= '0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         step_bit_ff       <= step_bit_in;
         search_value_ff   <= search_value_in;
         candidate_ff      <= candidate_in;
         best_trim_ff      <= best_trim_in;
         best_deviation_ff <= best_deviation_in;
      end
   end

   a_start_loads_top_bit: assert property (@(posedge clock) disable iff (reset)
      accept && command == CMD_START |=> phase_ff == PH_SEARCH && step_bit_ff == STEP_TOP
         && search_value_ff == '0)
      else $error("start did not load the search");

   a_search_step_onehot: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SEARCH |-> $onehot(step_bit_ff))
      else $error("search step is not a single bit");

   a_done_from_neigh: assert property (@(posedge clock) disable iff (reset)
      accept && result.done_res |-> phase_ff == PH_NEIGH && command == CMD_MEASURE)
      else $error("done outside the neighbourhood search");

   // one extra bit so the top candidate does not wrap
   a_candidate_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_NEIGH |-> candidate_ff <= top
         && (TRIM_BITS+1)'(candidate_ff) + 1'b1 >= (TRIM_BITS+1)'(search_value_ff))
      else $error("candidate left the neighbourhood");

endmodule

// ===== design/otc_out_buf.sv =====
module otc_out_buf import otc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  otc_result_type push_data,
   output logic           can_push,
   otc_rsp_if.source      rsp_if
);

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   otc_result_type out_data_ff, out_data_in;
   otc_result_type skid_data_ff, skid_data_in;
   logic           pop;

   assign can_push = !skid_valid_ff;
   assign pop      = out_valid_ff && rsp_if.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         // output held by the receiver, park the new transaction
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.trim     = out_data_ff.trim;
   assign rsp_if.done_res = out_data_ff.done_res;

endmodule

// ===== design/oscillator_trim_calibrator_unit.sv =====
// oscillator trim calibrator
// req_if carries commands: command 0 starts a calibration, command 1 delivers
// the frame length measured with the trim last presented on rsp_if.
// every accepted request transaction yields exactly one rsp_if transaction
// holding the trim to apply next and done_res, set on the final calibrated trim.
// a calibration is a start, eight bit-test measurements and two or three
// neighbourhood measurements; a measurement while idle returns the current trim.
// the response is registered in the output buffer; one request is taken per
// cycle while the skid entry is free, the state update being a single compare,
// subtract and select between the state registers and the result register.
// a two-entry output buffer (result register plus skid) keeps req_if.ready high
// for one extra transaction while the receiver stalls, then drops it until
// the receiver takes a response.
// target_length is written over the csr_ apb port at byte address 0; the user
// is to write it only while idle, which the block leaves unchecked. synchronous
// reset clears the search state, the trim to 0 and the target length to 2356.
module oscillator_trim_calibrator_unit import otc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   otc_req_if.sink                  req_if,
   otc_rsp_if.source                rsp_if,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [LENGTH_BITS-1:0] target_length;
   logic                   can_push;
   logic                   accept;
   otc_result_type         result;

   assign req_if.ready = can_push;
   assign accept       = req_if.valid && can_push;

   otc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .target_length (target_length)
   );

   otc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_if.command),
      .frame_length  (req_if.frame_length),
      .target_length (target_length),
      .result        (result)
   );

   otc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .can_push  (can_push),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== test/oscillator_trim_calibrator_unit_tb.sv =====
`timescale 1ns / 1ps

module oscillator_trim_calibrator_unit_tb;
   import otc_pkg::*;

   localparam int CYCLE_LIMIT  = 500_000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS  = 360;
   localparam logic [CSR_ADDR_BITS-1:0] TARGET_ADDR = CSR_ADDR_BITS'(4 * REG_TARGET_LENGTH);
   localparam logic [TRIM_BITS-1:0]     TRIM_MAX    = '1;

   typedef enum logic [1:0] {CAL_IDLE, CAL_SEARCH, CAL_NEIGH} cal_phase_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   otc_req_if req_if ();
   otc_rsp_if rsp_if ();

   oscillator_trim_calibrator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // calibrator state as the testbench sees it
   cal_phase_type          cal_phase  = CAL_IDLE;
   logic [TRIM_BITS-1:0]   probe_bit  = '0;
   logic [TRIM_BITS-1:0]   coarse_trim = '0;
   logic [TRIM_BITS-1:0]   cand_trim  = '0;
   logic [TRIM_BITS-1:0]   best_trim  = '0;
   logic [LENGTH_BITS-1:0] best_dev   = '0;
   logic [LENGTH_BITS-1:0] cfg_target = TARGET_RESET;

   otc_result_type expected_trims[$];
   otc_result_type oldest_trim;

   int error_count = 0;
   int sent_count  = 0;
   int cycle_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;

   // oscillator model used to make plausible frame lengths
   int osc_base;
   int osc_slope;
   int osc_noise;
   bit osc_scrambled;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic otc_result_type predict_trim(input logic cmd,
                                                   input logic [LENGTH_BITS-1:0] len);
      otc_result_type         res;
      logic [LENGTH_BITS-1:0] dev;
      logic [TRIM_BITS-1:0]   top;
      res.done_res = 1'b0;
      if (cmd == CMD_START) begin
         cal_phase   = CAL_SEARCH;
         probe_bit   = TRIM_BITS'(1) << (TRIM_BITS - 1);
         coarse_trim = '0;
         res.trim    = probe_bit;
      end else begin
         case (cal_phase)
            CAL_SEARCH: begin
               if (len < cfg_target)
                  coarse_trim = coarse_trim + probe_bit;
               probe_bit = probe_bit >> 1;
               if (probe_bit != '0) begin
                  res.trim = coarse_trim + probe_bit;
               end else begin
                  // last bit decided, neighbourhood starts one below
                  best_trim = coarse_trim;
                  best_dev  = len;
                  cand_trim = (coarse_trim == '0) ? '0 : coarse_trim - 1'b1;
                  cal_phase = CAL_NEIGH;
                  res.trim  = cand_trim;
               end
            end
            CAL_NEIGH: begin
               dev = (len >= cfg_target) ? len - cfg_target : cfg_target - len;
               if (dev < best_dev) begin
                  best_dev  = dev;
                  best_trim = cand_trim;
               end
               top = (coarse_trim == TRIM_MAX) ? TRIM_MAX : coarse_trim + 1'b1;
               if (cand_trim < top) begin
                  cand_trim = cand_trim + 1'b1;
                  res.trim  = cand_trim;
               end else begin
                  cal_phase    = CAL_IDLE;
                  res.trim     = best_trim;
                  res.done_res = 1'b1;
               end
            end
            default: begin
               cal_phase = CAL_IDLE;
               res.trim  = best_trim;
            end
         endcase
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_trims.size() == 0) begin
               report_mismatch("response with nothing pending, trim", rsp_if.trim, -1);
            end else begin
               oldest_trim = expected_trims.pop_front();
               if (rsp_if.trim !== oldest_trim.trim)
                  report_mismatch("trim", rsp_if.trim, oldest_trim.trim);
               if (rsp_if.done_res !== oldest_trim.done_res)
                  report_mismatch("done_res", rsp_if.done_res, oldest_trim.done_res);
            end
         end
         if (req_if.valid && req_if.ready)
            expected_trims.push_back(predict_trim(req_if.command, req_if.frame_length));
      end
   end

   // called at a rising edge, returns at the edge where the transaction is taken
   task automatic send_item(input logic cmd, input logic [LENGTH_BITS-1:0] len);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.command      <= cmd;
      req_if.frame_length <= len;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_for_results;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_trims.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic [LENGTH_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TARGET_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      cfg_target = value;
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(value))
         report_mismatch("target_length read back", csr_prdata, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [LENGTH_BITS-1:0] frame_for_trim(input int trial);
      int v;
      if (osc_scrambled)
         return LENGTH_BITS'($urandom);
      v = osc_base + osc_slope * trial + int'($urandom_range(osc_noise));
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return LENGTH_BITS'(v);
   endfunction

   // one calibration; cut stops it after that many measurements, negative runs it out
   task automatic run_calibration(input int cut);
      logic [TRIM_BITS-1:0]   acc;
      logic [TRIM_BITS-1:0]   probe;
      logic [TRIM_BITS-1:0]   lo;
      logic [TRIM_BITS-1:0]   hi;
      logic [LENGTH_BITS-1:0] len;
      int                     n;
      n   = 0;
      acc = '0;
      send_item(CMD_START, LENGTH_BITS'($urandom));
      for (int b = TRIM_BITS - 1; b >= 0; b--) begin
         if (n == cut)
            return;
         probe = acc | (TRIM_BITS'(1) << b);
         len   = frame_for_trim(probe);
         send_item(CMD_MEASURE, len);
         n++;
         if (len < cfg_target)
            acc = probe;
      end
      lo = (acc == '0) ? '0 : acc - 1'b1;
      hi = (acc == TRIM_MAX) ? TRIM_MAX : acc + 1'b1;
      for (int c = lo; c <= hi; c++) begin
         if (n == cut)
            return;
         send_item(CMD_MEASURE, frame_for_trim(c));
         n++;
      end
   endtask

   task automatic run_random_sequence;
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_item(1'($urandom_range(1)), LENGTH_BITS'($urandom));
         return;
      end
      osc_slope     = int'($urandom_range(60));
      osc_base      = int'(cfg_target) - osc_slope * int'($urandom_range(255));
      osc_noise     = (pick < 30) ? int'($urandom_range(2000)) : int'($urandom_range(3));
      osc_scrambled = (pick >= 92);
      run_calibration(($urandom_range(9) < 2) ? int'($urandom_range(10)) : -1);
      // stray measurement once the search has finished or been cut short
      if ($urandom_range(6) == 0)
         send_item(CMD_MEASURE, LENGTH_BITS'($urandom));
   endtask

   task automatic test_idle_measurement;
      send_item(CMD_MEASURE, '1);
      send_item(CMD_MEASURE, '0);
      wait_for_results();
   endtask

   // target at zero pins the search to trim 0, with a restart part way in
   task automatic test_floor_and_restart;
      write_target('0);
      osc_base      = 65535;
      osc_slope     = 0;
      osc_noise     = 0;
      osc_scrambled = 1'b0;
      send_item(CMD_START, '1);
      send_item(CMD_MEASURE, '0);
      run_calibration(-1);
      wait_for_results();
   endtask

   // target at its maximum drives the search to the top trim
   task automatic test_ceiling;
      write_target('1);
      osc_base = 0;
      run_calibration(-1);
      send_item(CMD_MEASURE, LENGTH_BITS'($urandom));
      wait_for_results();
   endtask

   task automatic test_random_phase(input int idle, input int stall,
                                    input logic [LENGTH_BITS-1:0] target);
      int stop_at;
      write_target(target);
      idle_pct  = idle;
      stall_pct = stall;
      stop_at   = sent_count + PHASE_ITEMS;
      while (sent_count < stop_at)
         run_random_sequence();
      wait_for_results();
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.command      <= CMD_START;
      req_if.frame_length <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_measurement();
      test_floor_and_restart();
      test_ceiling();
      test_random_phase(0, 0, TARGET_RESET);
      test_random_phase(55, 0, LENGTH_BITS'($urandom));
      test_random_phase(0, 55, LENGTH_BITS'($urandom_range(1000, 5000)));
      test_random_phase(9, 9, LENGTH_BITS'($urandom));

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
